// File: sv/hrbt_pkg.sv
// Package: shared types, codes and name tables of the request byte tokenizer.
`default_nettype none
package hrbt_pkg;

  localparam int TOKEN_BYTES_DEF = 8;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam int METHOD_COUNT  = 17;
  localparam int VERSION_COUNT = 5;
  localparam int NAME_BYTES    = 8;

  localparam logic [4:0] METHOD_UNKNOWN  = 5'd17;
  localparam logic [2:0] VERSION_UNKNOWN = 3'd5;

  typedef enum logic [2:0] {
    PH_METHOD  = 3'd0,
    PH_PATH    = 3'd1,
    PH_QNAME   = 3'd2,
    PH_QVALUE  = 3'd3,
    PH_VERSION = 3'd4,
    PH_HNAME   = 3'd5,
    PH_HVALUE  = 3'd6,
    PH_BODY    = 3'd7
  } phase_t;

  localparam logic [3:0] KIND_NONE    = 4'd0;
  localparam logic [3:0] KIND_METHOD  = 4'd1;
  localparam logic [3:0] KIND_PATH    = 4'd2;
  localparam logic [3:0] KIND_QNAME   = 4'd3;
  localparam logic [3:0] KIND_QVALUE  = 4'd4;
  localparam logic [3:0] KIND_VERSION = 4'd5;
  localparam logic [3:0] KIND_HNAME   = 4'd6;
  localparam logic [3:0] KIND_HVALUE  = 4'd7;
  localparam logic [3:0] KIND_BODY    = 4'd8;

  localparam logic [3:0] EV_NONE          = 4'd0;
  localparam logic [3:0] EV_METHOD_END    = 4'd1;
  localparam logic [3:0] EV_PATH_END      = 4'd2;
  localparam logic [3:0] EV_QUERY_PAIR    = 4'd3;
  localparam logic [3:0] EV_QNAME_DROP    = 4'd4;
  localparam logic [3:0] EV_VERSION_END   = 4'd5;
  localparam logic [3:0] EV_HEADER_STORED = 4'd6;
  localparam logic [3:0] EV_HNAME_DISCARD = 4'd7;
  localparam logic [3:0] EV_HEADERS_END   = 4'd8;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QMARK = 8'h3F;
  localparam logic [7:0] CH_EQUAL = 8'h3D;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_COLON = 8'h3A;

  // Byte 0 of a name is its first character; shorter names are padded with zeros.
  typedef logic [0:NAME_BYTES-1][7:0] name_t;

  localparam name_t METHOD_NAMES [METHOD_COUNT] = '{
    {"GET", 40'h0}, {"POST", 32'h0}, {"DELETE", 16'h0}, {"PUT", 40'h0},
    {"PATCH", 24'h0}, {"HEAD", 32'h0}, {"OPTIONS", 8'h0}, {"CONNECT", 8'h0},
    {"TRACE", 24'h0}, {"COPY", 32'h0}, {"LINK", 32'h0}, {"UNLINK", 16'h0},
    {"PURGE", 24'h0}, {"LOCK", 32'h0}, {"UNLOCK", 16'h0}, "PROPFIND",
    {"VIEW", 32'h0}
  };

  localparam logic [3:0] METHOD_LENS [METHOD_COUNT] = '{
    4'd3, 4'd4, 4'd6, 4'd3, 4'd5, 4'd4, 4'd7, 4'd7, 4'd5,
    4'd4, 4'd4, 4'd6, 4'd5, 4'd4, 4'd6, 4'd8, 4'd4
  };

  localparam name_t VERSION_NAMES [VERSION_COUNT] = '{
    "HTTP/0.9", "HTTP/1.0", "HTTP/1.1", "HTTP/2.0", "HTTP/3.0"
  };

  localparam logic [3:0] VERSION_LEN = 4'd8;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [3:0] field_kind;
    logic [3:0] close_event;
    logic [4:0] method_code;
    logic [2:0] version_code;
    logic       end_of_message;
  } result_t;

  // Classified word passed from the front to the back through the queue.
  typedef struct packed {
    logic [7:0]               data_byte;
    logic                     last_byte;
    logic [3:0]               field_kind;
    logic [3:0]               close_event;
    logic [METHOD_COUNT-1:0]  method_hit;
    logic [VERSION_COUNT-1:0] version_hit;
  } cls_word_t;

endpackage
`default_nettype wire

// File: sv/hrbt_front.sv
// Front end: accepts request bytes, tracks the parse phase and matches method and version text.
`default_nettype none
module hrbt_front #(
  parameter int TOKEN_BYTES = hrbt_pkg::TOKEN_BYTES_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire hrbt_pkg::item_t   item,
  input  wire logic              accept,
  output hrbt_pkg::cls_word_t    word
);

  localparam int LEN_W = $clog2(TOKEN_BYTES + 1);

  hrbt_pkg::phase_t phase, phase_next;
  logic             skip, skip_next;
  logic [LEN_W-1:0] tok_len;
  logic             tok_ovf;
  logic [hrbt_pkg::METHOD_COUNT-1:0]  m_alive, m_alive_next, m_hit;
  logic [hrbt_pkg::VERSION_COUNT-1:0] v_alive, v_alive_next, v_hit;
  logic             tok_clear, tok_push;
  logic [3:0]       kind, ev;
  logic [7:0]       d;

  assign d = item.data_byte;

  // Candidate names stay alive while every byte so far agrees with them.
  always_comb begin
    for (int i = 0; i < hrbt_pkg::METHOD_COUNT; i++) begin
      m_alive_next[i] = m_alive[i] && (tok_len < LEN_W'(hrbt_pkg::METHOD_LENS[i])) &&
                        (hrbt_pkg::METHOD_NAMES[i][tok_len[2:0]] == d);
      m_hit[i] = !tok_ovf && m_alive[i] && (tok_len == LEN_W'(hrbt_pkg::METHOD_LENS[i]));
    end
    for (int i = 0; i < hrbt_pkg::VERSION_COUNT; i++) begin
      v_alive_next[i] = v_alive[i] && (tok_len < LEN_W'(hrbt_pkg::VERSION_LEN)) &&
                        (hrbt_pkg::VERSION_NAMES[i][tok_len[2:0]] == d);
      v_hit[i] = !tok_ovf && v_alive[i] && (tok_len == LEN_W'(hrbt_pkg::VERSION_LEN));
    end
  end

  always_comb begin
    phase_next = phase;
    skip_next  = 1'b0;
    kind       = hrbt_pkg::KIND_NONE;
    ev         = hrbt_pkg::EV_NONE;
    tok_clear  = 1'b0;
    tok_push   = 1'b0;
    if (!skip) begin
      case (phase)
        hrbt_pkg::PH_METHOD: begin
          if (d == hrbt_pkg::CH_SPACE) begin
            ev         = hrbt_pkg::EV_METHOD_END;
            tok_clear  = 1'b1;
            phase_next = hrbt_pkg::PH_PATH;
          end else begin
            kind     = hrbt_pkg::KIND_METHOD;
            tok_push = 1'b1;
          end
        end
        hrbt_pkg::PH_PATH: begin
          if (d == hrbt_pkg::CH_SPACE) begin
            ev         = hrbt_pkg::EV_PATH_END;
            phase_next = hrbt_pkg::PH_VERSION;
          end else if (d == hrbt_pkg::CH_QMARK) begin
            ev         = hrbt_pkg::EV_PATH_END;
            phase_next = hrbt_pkg::PH_QNAME;
          end else begin
            kind = hrbt_pkg::KIND_PATH;
          end
        end
        hrbt_pkg::PH_QNAME: begin
          if (d == hrbt_pkg::CH_SPACE) begin
            ev         = hrbt_pkg::EV_QNAME_DROP;
            phase_next = hrbt_pkg::PH_VERSION;
          end else if (d == hrbt_pkg::CH_EQUAL) begin
            phase_next = hrbt_pkg::PH_QVALUE;
          end else begin
            kind = hrbt_pkg::KIND_QNAME;
          end
        end
        hrbt_pkg::PH_QVALUE: begin
          if (d == hrbt_pkg::CH_SPACE) begin
            ev         = hrbt_pkg::EV_QUERY_PAIR;
            phase_next = hrbt_pkg::PH_VERSION;
          end else if (d == hrbt_pkg::CH_AMP) begin
            ev         = hrbt_pkg::EV_QUERY_PAIR;
            phase_next = hrbt_pkg::PH_QNAME;
          end else begin
            kind = hrbt_pkg::KIND_QVALUE;
          end
        end
        hrbt_pkg::PH_VERSION: begin
          if (d == hrbt_pkg::CH_LF) begin
            ev         = hrbt_pkg::EV_VERSION_END;
            tok_clear  = 1'b1;
            phase_next = hrbt_pkg::PH_HNAME;
          end else if (d != hrbt_pkg::CH_CR) begin
            kind     = hrbt_pkg::KIND_VERSION;
            tok_push = 1'b1;
          end
        end
        hrbt_pkg::PH_HNAME: begin
          if (d == hrbt_pkg::CH_LF) begin
            ev         = hrbt_pkg::EV_HEADERS_END;
            phase_next = hrbt_pkg::PH_BODY;
          end else if (d == hrbt_pkg::CH_SPACE) begin
            ev = hrbt_pkg::EV_HNAME_DISCARD;
          end else if (d == hrbt_pkg::CH_COLON) begin
            phase_next = hrbt_pkg::PH_HVALUE;
            skip_next  = 1'b1;
          end else begin
            kind = hrbt_pkg::KIND_HNAME;
          end
        end
        hrbt_pkg::PH_HVALUE: begin
          if (d == hrbt_pkg::CH_LF) begin
            ev         = hrbt_pkg::EV_HEADER_STORED;
            phase_next = hrbt_pkg::PH_HNAME;
          end else if (d != hrbt_pkg::CH_CR) begin
            kind = hrbt_pkg::KIND_HVALUE;
          end
        end
        hrbt_pkg::PH_BODY: begin
          kind = hrbt_pkg::KIND_BODY;
        end
        default: begin
          kind = hrbt_pkg::KIND_BODY;
        end
      endcase
    end
  end

  always_comb begin
    word.data_byte   = d;
    word.last_byte   = item.last_byte;
    word.field_kind  = kind;
    word.close_event = ev;
    word.method_hit  = (ev == hrbt_pkg::EV_METHOD_END) ? m_hit : '0;
    word.version_hit = (ev == hrbt_pkg::EV_VERSION_END) ? v_hit : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= hrbt_pkg::PH_METHOD;
      skip    <= 1'b0;
      tok_len <= '0;
      tok_ovf <= 1'b0;
      m_alive <= '1;
      v_alive <= '1;
    end else if (accept) begin
      if (item.last_byte) begin
        phase   <= hrbt_pkg::PH_METHOD;
        skip    <= 1'b0;
        tok_len <= '0;
        tok_ovf <= 1'b0;
        m_alive <= '1;
        v_alive <= '1;
      end else begin
        phase <= phase_next;
        skip  <= skip_next;
        if (tok_clear) begin
          tok_len <= '0;
          tok_ovf <= 1'b0;
          m_alive <= '1;
          v_alive <= '1;
        end else if (tok_push) begin
          if (tok_len < LEN_W'(TOKEN_BYTES)) begin
            tok_len <= tok_len + LEN_W'(1);
            m_alive <= m_alive_next;
            v_alive <= v_alive_next;
          end else begin
            tok_ovf <= 1'b1;
          end
        end
      end
    end
  end

endmodule
`default_nettype wire

// File: sv/hrbt_queue.sv
// Short queue of classified words between the front and the back.
`default_nettype none
module hrbt_queue #(
  parameter int DEPTH = hrbt_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                wr_en,
  input  wire hrbt_pkg::cls_word_t wr_word,
  output logic                     full,
  input  wire logic                rd_en,
  output hrbt_pkg::cls_word_t      rd_word,
  output logic                     empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  hrbt_pkg::cls_word_t mem [DEPTH];
  logic [PTR_W-1:0] wptr, rptr;
  logic [CNT_W-1:0] count;
  logic             do_wr, do_rd;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_word = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wptr] <= wr_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wptr <= (wptr == PTR_W'(DEPTH - 1)) ? '0 : wptr + PTR_W'(1);
      end
      if (do_rd) begin
        rptr <= (rptr == PTR_W'(DEPTH - 1)) ? '0 : rptr + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

// File: sv/hrbt_back.sv
// Back end: turns match flags into method and version codes and holds the result register.
`default_nettype none
module hrbt_back (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire hrbt_pkg::cls_word_t word,
  input  wire logic                word_valid,
  output logic                     word_take,
  output hrbt_pkg::result_t        result,
  output logic                     empty,
  input  wire logic                pop
);

  logic              out_valid;
  logic [4:0]        mcode;
  logic [2:0]        vcode;
  hrbt_pkg::result_t res_next;

  // Names in each table are distinct, so at most one flag is set; the first wins.
  always_comb begin
    mcode = hrbt_pkg::METHOD_UNKNOWN;
    for (int i = hrbt_pkg::METHOD_COUNT - 1; i >= 0; i--) begin
      if (word.method_hit[i]) begin
        mcode = 5'(i);
      end
    end
    vcode = hrbt_pkg::VERSION_UNKNOWN;
    for (int i = hrbt_pkg::VERSION_COUNT - 1; i >= 0; i--) begin
      if (word.version_hit[i]) begin
        vcode = 3'(i);
      end
    end
  end

  always_comb begin
    res_next.out_byte       = word.data_byte;
    res_next.field_kind     = word.field_kind;
    res_next.close_event    = word.close_event;
    res_next.method_code    = (word.close_event == hrbt_pkg::EV_METHOD_END) ? mcode : 5'd0;
    res_next.version_code   = (word.close_event == hrbt_pkg::EV_VERSION_END) ? vcode : 3'd0;
    res_next.end_of_message = word.last_byte;
  end

  assign empty     = !out_valid;
  assign word_take = word_valid && (!out_valid || pop);

  always_ff @(posedge clk) begin
    if (word_take) begin
      result <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (word_take) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  a_rst_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result register not empty after reset");
  a_mcode_only_at_method_end: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.close_event != hrbt_pkg::EV_METHOD_END) |-> result.method_code == 5'd0)
    else $error("method code outside method end");
  a_vcode_only_at_version_end: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.close_event != hrbt_pkg::EV_VERSION_END) |-> result.version_code == 3'd0)
    else $error("version code outside version end");
  a_kind_excludes_event: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.field_kind != hrbt_pkg::KIND_NONE) |-> result.close_event == hrbt_pkg::EV_NONE)
    else $error("tagged byte also closes a field");
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(result)))
    else $error("waiting result changed under stall");

endmodule
`default_nettype wire

// File: sv/http_request_byte_tokenizer_unit.sv
// Top level of the request byte tokenizer: front end, word queue and result stage.
// Usage:
//   Input words (one request byte plus a last-byte mark) are offered on item and
//   taken at a rising edge where push is high and full is low.
//   Results leave on result; the oldest one is shown while empty is low and is
//   taken at a rising edge where pop is high and empty is low.
//   Each input word gives exactly one result: the byte, its field tag, any
//   field-closing event and, at method or version end, the matched code.
//   The byte is classified and written to the queue at the accepting edge, and
//   the result register loads it from the queue once that register is free
//   and no older word waits ahead of it.
//   Throughput: one byte per cycle while full is low; method and version
//   names are matched as bytes arrive, so the closing delimiter adds no wait.
//   When the consumer stalls, the result register holds and the queue between
//   the front and the back absorbs up to QUEUE_DEPTH words before full rises.
//   Reset (synchronous, rst high) empties the queue and result register and
//   puts the parser back at the start of a request; the byte marked last does
//   the same to the parser after its own result has been formed.
`default_nettype none
module http_request_byte_tokenizer_unit #(
  parameter int TOKEN_BYTES = hrbt_pkg::TOKEN_BYTES_DEF,
  parameter int QUEUE_DEPTH = hrbt_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire hrbt_pkg::item_t item,
  output logic                 full,
  input  wire logic            pop,
  output hrbt_pkg::result_t    result,
  output logic                 empty
);

  hrbt_pkg::cls_word_t fe_word, q_word;
  logic                accept, q_empty, q_take;

  assign accept = push && !full;

  hrbt_front #(
    .TOKEN_BYTES (TOKEN_BYTES)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .accept (accept),
    .word   (fe_word)
  );

  hrbt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (accept),
    .wr_word (fe_word),
    .full    (full),
    .rd_en   (q_take),
    .rd_word (q_word),
    .empty   (q_empty)
  );

  hrbt_back u_back (
    .clk        (clk),
    .rst        (rst),
    .word       (q_word),
    .word_valid (!q_empty),
    .word_take  (q_take),
    .result     (result),
    .empty      (empty),
    .pop        (pop)
  );

endmodule
`default_nettype wire

// File: sim/tb_http_request_byte_tokenizer_unit.sv
// Testbench for the request byte tokenizer: directed table, random requests, checked against a predictor.
`timescale 1ns / 100ps
module tb_http_request_byte_tokenizer_unit;

  localparam int NAME_ROOM    = hrbt_pkg::TOKEN_BYTES_DEF;
  localparam int PHASE_BYTES  = 250;
  localparam int QUIET_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 8;
  localparam int REPORT_MAX   = 10;

  // Percentages per phase: sender idle, receiver stalling.
  localparam int SEND_IDLE [4]  = '{0, 52, 0, 9};
  localparam int TAKE_STALL [4] = '{0, 0, 52, 9};

  typedef struct packed {
    hrbt_pkg::item_t   word;
    logic              pinned;
    hrbt_pkg::result_t want;
  } step_t;

  localparam int DIRECTED_ROWS = 26;
  localparam step_t DIRECTED [DIRECTED_ROWS] = '{
    '{'{8'hFF, 1'b0}, 1'b1,
      '{8'hFF, hrbt_pkg::KIND_METHOD, hrbt_pkg::EV_NONE, 5'd0, 3'd0, 1'b0}},
    '{'{hrbt_pkg::CH_SPACE, 1'b0}, 1'b1,
      '{hrbt_pkg::CH_SPACE, hrbt_pkg::KIND_NONE, hrbt_pkg::EV_METHOD_END,
        hrbt_pkg::METHOD_UNKNOWN, 3'd0, 1'b0}},
    '{'{"/", 1'b0}, 1'b0, '0},
    '{'{hrbt_pkg::CH_QMARK, 1'b0}, 1'b0, '0},
    '{'{"a", 1'b0}, 1'b0, '0},
    '{'{hrbt_pkg::CH_EQUAL, 1'b0}, 1'b0, '0},
    '{'{"b", 1'b0}, 1'b0, '0},
    '{'{hrbt_pkg::CH_AMP, 1'b0}, 1'b0, '0},
    '{'{"c", 1'b0}, 1'b0, '0},
    '{'{hrbt_pkg::CH_SPACE, 1'b0}, 1'b0, '0},
    '{'{"V", 1'b0}, 1'b0, '0},
    '{'{hrbt_pkg::CH_CR, 1'b0}, 1'b0, '0},
    '{'{hrbt_pkg::CH_LF, 1'b0}, 1'b1,
      '{hrbt_pkg::CH_LF, hrbt_pkg::KIND_NONE, hrbt_pkg::EV_VERSION_END, 5'd0,
        hrbt_pkg::VERSION_UNKNOWN, 1'b0}},
    '{'{hrbt_pkg::CH_SPACE, 1'b0}, 1'b0, '0},
    '{'{hrbt_pkg::CH_COLON, 1'b0}, 1'b0, '0},
    '{'{8'h00, 1'b0}, 1'b1,
      '{8'h00, hrbt_pkg::KIND_NONE, hrbt_pkg::EV_NONE, 5'd0, 3'd0, 1'b0}},
    '{'{"x", 1'b0}, 1'b0, '0},
    '{'{hrbt_pkg::CH_CR, 1'b0}, 1'b0, '0},
    '{'{hrbt_pkg::CH_LF, 1'b0}, 1'b0, '0},
    '{'{hrbt_pkg::CH_CR, 1'b0}, 1'b0, '0},
    '{'{hrbt_pkg::CH_LF, 1'b0}, 1'b0, '0},
    '{'{8'h00, 1'b1}, 1'b1,
      '{8'h00, hrbt_pkg::KIND_BODY, hrbt_pkg::EV_NONE, 5'd0, 3'd0, 1'b1}},
    '{'{"G", 1'b0}, 1'b0, '0},
    '{'{"E", 1'b0}, 1'b0, '0},
    '{'{"T", 1'b0}, 1'b0, '0},
    '{'{hrbt_pkg::CH_SPACE, 1'b1}, 1'b1,
      '{hrbt_pkg::CH_SPACE, hrbt_pkg::KIND_NONE, hrbt_pkg::EV_METHOD_END, 5'd0, 3'd0, 1'b1}}
  };

  string method_words [hrbt_pkg::METHOD_COUNT] = '{
    "GET", "POST", "DELETE", "PUT", "PATCH", "HEAD", "OPTIONS", "CONNECT", "TRACE",
    "COPY", "LINK", "UNLINK", "PURGE", "LOCK", "UNLOCK", "PROPFIND", "VIEW"
  };
  string version_words [hrbt_pkg::VERSION_COUNT] = '{
    "HTTP/0.9", "HTTP/1.0", "HTTP/1.1", "HTTP/2.0", "HTTP/3.0"
  };
  string text_chars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789-./";

  logic              clk;
  logic              rst = 1'b1;
  logic              push = 1'b0;
  hrbt_pkg::item_t   item = '0;
  logic              full;
  logic              pop = 1'b0;
  hrbt_pkg::result_t result;
  logic              empty;

  // Typed-in expectation travelling alongside the word on the input side.
  logic              item_pin = 1'b0;
  hrbt_pkg::result_t item_want = '0;

  int send_idle_pct = 0;
  int take_stall_pct = 0;
  int bytes_sent = 0;
  int fault_count = 0;
  int quiet_cycles = 0;

  hrbt_pkg::result_t expected_tags [$];
  logic [7:0]        request_bytes [$];

  // Predictor state.
  hrbt_pkg::phase_t req_phase = hrbt_pkg::PH_METHOD;
  logic             skip_byte = 1'b0;
  logic [7:0]       name_buf [NAME_ROOM];
  int               name_len = 0;
  logic             name_long = 1'b0;

  http_request_byte_tokenizer_unit dut (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .item   (item),
    .full   (full),
    .pop    (pop),
    .result (result),
    .empty  (empty)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void keep_name_byte(logic [7:0] b);
    if (name_len < NAME_ROOM) begin
      name_buf[name_len] = b;
      name_len++;
    end else begin
      name_long = 1'b1;
    end
  endfunction

  function automatic bit name_is(string s);
    if (name_long || s.len() != name_len) return 1'b0;
    for (int i = 0; i < name_len; i++)
      if (name_buf[i] != s[i]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic hrbt_pkg::result_t tokenize_byte(hrbt_pkg::item_t w);
    hrbt_pkg::result_t r;
    logic [7:0]        b;
    b = w.data_byte;
    r = '0;
    r.out_byte = b;
    r.end_of_message = w.last_byte;
    if (skip_byte) begin
      skip_byte = 1'b0;
    end else begin
      case (req_phase)
        hrbt_pkg::PH_METHOD: begin
          if (b == hrbt_pkg::CH_SPACE) begin
            r.close_event = hrbt_pkg::EV_METHOD_END;
            r.method_code = hrbt_pkg::METHOD_UNKNOWN;
            for (int i = 0; i < hrbt_pkg::METHOD_COUNT; i++)
              if (r.method_code == hrbt_pkg::METHOD_UNKNOWN && name_is(method_words[i]))
                r.method_code = 5'(i);
            name_len = 0;
            name_long = 1'b0;
            req_phase = hrbt_pkg::PH_PATH;
          end else begin
            r.field_kind = hrbt_pkg::KIND_METHOD;
            keep_name_byte(b);
          end
        end
        hrbt_pkg::PH_PATH: begin
          if (b == hrbt_pkg::CH_SPACE || b == hrbt_pkg::CH_QMARK) begin
            r.close_event = hrbt_pkg::EV_PATH_END;
            req_phase = (b == hrbt_pkg::CH_SPACE) ? hrbt_pkg::PH_VERSION : hrbt_pkg::PH_QNAME;
          end else begin
            r.field_kind = hrbt_pkg::KIND_PATH;
          end
        end
        hrbt_pkg::PH_QNAME: begin
          if (b == hrbt_pkg::CH_SPACE) begin
            r.close_event = hrbt_pkg::EV_QNAME_DROP;
            req_phase = hrbt_pkg::PH_VERSION;
          end else if (b == hrbt_pkg::CH_EQUAL) begin
            req_phase = hrbt_pkg::PH_QVALUE;
          end else begin
            r.field_kind = hrbt_pkg::KIND_QNAME;
          end
        end
        hrbt_pkg::PH_QVALUE: begin
          if (b == hrbt_pkg::CH_SPACE || b == hrbt_pkg::CH_AMP) begin
            r.close_event = hrbt_pkg::EV_QUERY_PAIR;
            req_phase = (b == hrbt_pkg::CH_SPACE) ? hrbt_pkg::PH_VERSION : hrbt_pkg::PH_QNAME;
          end else begin
            r.field_kind = hrbt_pkg::KIND_QVALUE;
          end
        end
        hrbt_pkg::PH_VERSION: begin
          if (b == hrbt_pkg::CH_LF) begin
            r.close_event = hrbt_pkg::EV_VERSION_END;
            r.version_code = hrbt_pkg::VERSION_UNKNOWN;
            for (int i = 0; i < hrbt_pkg::VERSION_COUNT; i++)
              if (r.version_code == hrbt_pkg::VERSION_UNKNOWN && name_is(version_words[i]))
                r.version_code = 3'(i);
            name_len = 0;
            name_long = 1'b0;
            req_phase = hrbt_pkg::PH_HNAME;
          end else if (b != hrbt_pkg::CH_CR) begin
            r.field_kind = hrbt_pkg::KIND_VERSION;
            keep_name_byte(b);
          end
        end
        hrbt_pkg::PH_HNAME: begin
          if (b == hrbt_pkg::CH_LF) begin
            r.close_event = hrbt_pkg::EV_HEADERS_END;
            req_phase = hrbt_pkg::PH_BODY;
          end else if (b == hrbt_pkg::CH_SPACE) begin
            r.close_event = hrbt_pkg::EV_HNAME_DISCARD;
          end else if (b == hrbt_pkg::CH_COLON) begin
            // The byte right after the colon is swallowed without a tag.
            req_phase = hrbt_pkg::PH_HVALUE;
            skip_byte = 1'b1;
          end else begin
            r.field_kind = hrbt_pkg::KIND_HNAME;
          end
        end
        hrbt_pkg::PH_HVALUE: begin
          if (b == hrbt_pkg::CH_LF) begin
            r.close_event = hrbt_pkg::EV_HEADER_STORED;
            req_phase = hrbt_pkg::PH_HNAME;
          end else if (b != hrbt_pkg::CH_CR) begin
            r.field_kind = hrbt_pkg::KIND_HVALUE;
          end
        end
        default: begin
          r.field_kind = hrbt_pkg::KIND_BODY;
        end
      endcase
    end
    if (w.last_byte) begin
      req_phase = hrbt_pkg::PH_METHOD;
      skip_byte = 1'b0;
      name_len = 0;
      name_long = 1'b0;
    end
    return r;
  endfunction

  function automatic void report_fault(string what, hrbt_pkg::result_t want,
                                       hrbt_pkg::result_t got);
    fault_count++;
    if (fault_count <= REPORT_MAX)
      $display({"%s: expected byte %h kind %0d event %0d method %0d version %0d last %0d,",
                " got byte %h kind %0d event %0d method %0d version %0d last %0d"},
               what, want.out_byte, want.field_kind, want.close_event, want.method_code,
               want.version_code, want.end_of_message, got.out_byte, got.field_kind,
               got.close_event, got.method_code, got.version_code, got.end_of_message);
  endfunction

  // Receiver side: pop is redrawn at every edge.
  always @(posedge clk) begin
    pop <= ($urandom_range(99) >= take_stall_pct);
  end

  always @(posedge clk) begin
    hrbt_pkg::result_t want;
    logic              moved;
    moved = 1'b0;
    if (!rst) begin
      if (pop && !empty) begin
        moved = 1'b1;
        if (expected_tags.size() == 0) begin
          report_fault("result with nothing expected", '0, result);
        end else begin
          want = expected_tags.pop_front();
          if (result.out_byte !== want.out_byte || result.field_kind !== want.field_kind ||
              result.close_event !== want.close_event ||
              result.method_code !== want.method_code ||
              result.version_code !== want.version_code ||
              result.end_of_message !== want.end_of_message)
            report_fault("mismatch", want, result);
        end
      end
      if (push && !full) begin
        moved = 1'b1;
        want = tokenize_byte(item);
        expected_tags.push_back(item_pin ? item_want : want);
      end
    end
    quiet_cycles = moved ? 0 : quiet_cycles + 1;
  end

  initial begin : watchdog
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  task automatic send_word(hrbt_pkg::item_t w, logic pin, hrbt_pkg::result_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    item <= w;
    item_pin <= pin;
    item_want <= want;
    @(posedge clk);
    while (full) @(posedge clk);
    bytes_sent++;
  endtask

  function automatic logic [7:0] text_byte();
    if ($urandom_range(9) == 0) return 8'($urandom_range(255));
    return text_chars[$urandom_range(text_chars.len() - 1)];
  endfunction

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) request_bytes.push_back(s[i]);
  endtask

  task automatic add_filler(int lo, int hi);
    repeat ($urandom_range(hi, lo)) request_bytes.push_back(text_byte());
  endtask

  // Mostly well-formed requests with random content; some cut short, some pure noise.
  task automatic build_request();
    int    pick;
    int    keep;
    string word;
    request_bytes.delete();
    pick = $urandom_range(99);
    if (pick >= 92) begin
      repeat ($urandom_range(12, 1)) request_bytes.push_back(8'($urandom_range(255)));
      return;
    end
    keep = (pick >= 80) ? 1 : 0;

    pick = $urandom_range(99);
    word = method_words[$urandom_range(hrbt_pkg::METHOD_COUNT - 1)];
    if (pick < 70) add_text(word);
    else if (pick < 78) add_text("UNKNOWN");
    else if (pick < 86) begin
      add_text(word);
      add_filler(9 - word.len(), 12 - word.len());
    end else if (pick < 92) add_filler(0, 4);
    else add_text(word.substr(0, word.len() - 2));
    request_bytes.push_back(hrbt_pkg::CH_SPACE);

    add_text("/");
    add_filler(0, 6);
    if ($urandom_range(1)) begin
      request_bytes.push_back(hrbt_pkg::CH_QMARK);
      repeat ($urandom_range(2)) begin
        add_filler(0, 4);
        if ($urandom_range(4) != 0) begin
          request_bytes.push_back(hrbt_pkg::CH_EQUAL);
          add_filler(0, 4);
        end
        request_bytes.push_back(hrbt_pkg::CH_AMP);
      end
      add_filler(0, 4);
      if ($urandom_range(4) != 0) begin
        request_bytes.push_back(hrbt_pkg::CH_EQUAL);
        add_filler(0, 4);
      end
    end
    request_bytes.push_back(hrbt_pkg::CH_SPACE);

    pick = $urandom_range(99);
    if (pick < 75) add_text(version_words[$urandom_range(hrbt_pkg::VERSION_COUNT - 1)]);
    else if (pick < 85) add_text("HTTP/1.10");
    else if (pick < 95) add_filler(0, 8);
    else add_text("HTTP/1.");
    if ($urandom_range(4) != 0) request_bytes.push_back(hrbt_pkg::CH_CR);
    request_bytes.push_back(hrbt_pkg::CH_LF);

    repeat ($urandom_range(3)) begin
      add_filler(1, 4);
      if ($urandom_range(9) == 0) begin
        request_bytes.push_back(hrbt_pkg::CH_SPACE);
        add_filler(1, 3);
      end
      request_bytes.push_back(hrbt_pkg::CH_COLON);
      if ($urandom_range(4) != 0) request_bytes.push_back(hrbt_pkg::CH_SPACE);
      add_filler(0, 8);
      if ($urandom_range(4) != 0) request_bytes.push_back(hrbt_pkg::CH_CR);
      request_bytes.push_back(hrbt_pkg::CH_LF);
    end
    if ($urandom_range(4) != 0) request_bytes.push_back(hrbt_pkg::CH_CR);
    request_bytes.push_back(hrbt_pkg::CH_LF);
    repeat ($urandom_range(5)) request_bytes.push_back(8'($urandom_range(255)));

    if (keep) request_bytes = request_bytes[0:$urandom_range(request_bytes.size() - 1)];
  endtask

  initial begin : stimulus
    hrbt_pkg::item_t w;
    int              phase_end;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIRECTED_ROWS; i++)
      send_word(DIRECTED[i].word, DIRECTED[i].pinned, DIRECTED[i].want);

    for (int p = 0; p < 4; p++) begin
      send_idle_pct = SEND_IDLE[p];
      take_stall_pct = TAKE_STALL[p];
      phase_end = bytes_sent + PHASE_BYTES;
      while (bytes_sent < phase_end) begin
        build_request();
        for (int i = 0; i < request_bytes.size(); i++) begin
          w.data_byte = request_bytes[i];
          w.last_byte = (i == request_bytes.size() - 1);
          send_word(w, 1'b0, '0);
        end
      end
    end
    push <= 1'b0;

    while (expected_tags.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fault_count == 0 && expected_tags.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
